// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cba_pkg.sv -----
// ----------------------------------------------------------------------------
// cba_pkg
// Shared widths, request kinds, status codes and register indexes of the
// contiguous block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

   localparam int WORD_W   = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int START_W  = 5;
   localparam int SIZE_W   = 6;
   localparam int CSR_IDX_W = 2;
   localparam int BCNT_W   = 6;
   localparam int DIV_STEPS = WORD_W;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_DELETE = 2'd1;
   localparam kind_type KIND_LIST   = 2'd2;

   localparam status_type ST_INSERTED = 3'd0;
   localparam status_type ST_NO_RUN   = 3'd1;
   localparam status_type ST_NO_MEM   = 3'd2;
   localparam status_type ST_DELETED  = 3'd3;
   localparam status_type ST_ABSENT   = 3'd4;
   localparam status_type ST_FULL     = 3'd5;
   localparam status_type ST_ENTRY    = 3'd6;
   localparam status_type ST_EMPTY    = 3'd7;

   localparam csr_idx_type REG_TOTAL_MEMORY = 2'd0;
   localparam csr_idx_type REG_BLOCK_COUNT  = 2'd1;
   localparam csr_idx_type REG_BLOCK_SIZE   = 2'd2;

   localparam word_type          RST_TOTAL_MEMORY = 16'd1024;
   localparam logic [BCNT_W-1:0] RST_BLOCK_COUNT  = 6'd32;
   localparam word_type          RST_BLOCK_SIZE   = 16'd32;

endpackage

`default_nettype wire

// ----- rtl/cba_div.sv -----
// ----------------------------------------------------------------------------
// cba_div
// Restoring divider, one quotient bit per cycle. Result valid on done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cba_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cba_pkg::word_type dividend,
   input  wire cba_pkg::word_type divisor,
   output logic                   done,
   output cba_pkg::word_type      quotient,
   output cba_pkg::word_type      remainder
);

   localparam int CNT_W = $clog2(cba_pkg::DIV_STEPS);
   localparam int W     = cba_pkg::WORD_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   cba_pkg::word_type rem_ff, rem_in;
   cba_pkg::word_type quo_ff, quo_in;
   cba_pkg::word_type div_ff, div_in;
   logic [W:0]        rem_sh;
   logic [W:0]        diff;

   assign rem_sh = {rem_ff, quo_ff[W-1]};
   assign diff   = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(cba_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit contiguous block allocator with an ordered file directory.
// ----------------------------------------------------------------------------
// Insert: divide the size by the block size, scan for a first-fit run of free blocks, mark it.
// Delete: search the entries in order, free the run, move later entries up. List: read, emit each entry.
// Directory full, short of memory, delete or list on an empty directory: result next cycle.
// One request at a time; busy is high while the sequencer works.
// Results are one-cycle strobes on rsp_valid; the receiver cannot stall.
// Reset (synchronous): all blocks free, directory empty, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module contiguous_block_allocator #(
   parameter int NUM_BLOCKS = 32,
   parameter int MAX_FILES  = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire cba_pkg::kind_type           req_kind,
   input  wire cba_pkg::word_type           req_file_name,
   input  wire cba_pkg::word_type           req_file_size,
   output logic                             rsp_valid,
   output cba_pkg::status_type              rsp_status,
   output cba_pkg::word_type                rsp_entry_name,
   output logic [cba_pkg::START_W-1:0]      rsp_start_block,
   output logic [cba_pkg::SIZE_W-1:0]       rsp_size_blocks,
   output logic                             rsp_last,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire cba_pkg::csr_idx_type        csr_index,
   input  wire cba_pkg::word_type           csr_data
);

   localparam int W    = cba_pkg::WORD_W;
   localparam int BW   = $clog2(NUM_BLOCKS);
   localparam int ZW   = $clog2(NUM_BLOCKS + 1);
   localparam int SUMW = ZW + 1;
   localparam int CW   = (ZW > cba_pkg::BCNT_W) ? ZW : cba_pkg::BCNT_W;
   localparam int FW   = $clog2(MAX_FILES);
   localparam int CNTW = $clog2(MAX_FILES + 1);
   localparam int PW   = ZW + W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIV      = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_MARK     = 4'd3;
   localparam logic [3:0] S_INS_DONE = 4'd4;
   localparam logic [3:0] S_FIND     = 4'd5;
   localparam logic [3:0] S_CMP      = 4'd6;
   localparam logic [3:0] S_FREE     = 4'd7;
   localparam logic [3:0] S_DEL_DONE = 4'd8;
   localparam logic [3:0] S_SH_RD    = 4'd9;
   localparam logic [3:0] S_SH_WR    = 4'd10;
   localparam logic [3:0] S_LST_RD   = 4'd11;
   localparam logic [3:0] S_LST_EM   = 4'd12;

   typedef struct packed {
      cba_pkg::word_type name;
      logic [BW-1:0]     first;
      logic [ZW-1:0]     blocks;
   } dir_entry_type;

   dir_entry_type dir_mem [MAX_FILES];
   dir_entry_type dir_rd_ff;
   dir_entry_type dir_wdata;
   logic [FW-1:0] dir_raddr;
   logic [FW-1:0] dir_waddr;
   logic          dir_we;

   logic [3:0]                 state_ff, state_in;
   logic [CNTW-1:0]            entry_count_ff, entry_count_in;
   logic [NUM_BLOCKS-1:0]      free_map_ff, free_map_in;
   cba_pkg::word_type          remaining_ff, remaining_in;
   logic [cba_pkg::BCNT_W-1:0] block_count_ff, block_count_in;
   cba_pkg::word_type          block_size_ff, block_size_in;
   cba_pkg::word_type          name_ff, name_in;
   cba_pkg::word_type          need_ff, need_in;
   logic [ZW-1:0]              idx_ff, idx_in;
   logic [ZW-1:0]              run_len_ff, run_len_in;
   logic [BW-1:0]              run_start_ff, run_start_in;
   logic [BW-1:0]              at_ff, at_in;
   logic [ZW-1:0]              sz_ff, sz_in;
   logic [FW-1:0]              ptr_ff, ptr_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cba_pkg::status_type        rsp_status_ff, rsp_status_in;
   cba_pkg::word_type          rsp_name_ff, rsp_name_in;
   logic [cba_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [cba_pkg::SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic                       div_start;
   logic                       div_done;
   cba_pkg::word_type          div_quo;
   cba_pkg::word_type          div_rem;
   cba_pkg::word_type          bs_eff;
   logic [ZW-1:0]              n_blocks;
   logic [NUM_BLOCKS-1:0]      range_mask;
   logic [ZW-1:0]              run_inc;
   logic [BW-1:0]              run_start_cur;
   logic [W:0]                 need_eff;
   logic [PW:0]                give_back;
   logic [CNTW-1:0]            ptr_next;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign bs_eff    = (block_size_ff == '0) ? W'(1) : block_size_ff;
   assign n_blocks  = (CW'(block_count_ff) >= CW'(NUM_BLOCKS)) ? ZW'(NUM_BLOCKS)
                                                                : ZW'(block_count_ff);
   assign run_inc       = run_len_ff + ZW'(1);
   assign run_start_cur = (run_len_ff == '0) ? idx_ff[BW-1:0] : run_start_ff;
   assign need_eff      = {1'b0, (need_ff == '0) ? W'(1) : need_ff};
   assign give_back     = (PW+1)'(prod_ff) + (PW+1)'(remaining_ff);
   assign ptr_next      = CNTW'(ptr_ff) + CNTW'(1);

   always_comb begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         range_mask[b] = (SUMW'(b) >= SUMW'(at_ff)) &&
                         (SUMW'(b) < SUMW'(at_ff) + SUMW'(sz_ff));
      end
   end

   cba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_file_size),
      .divisor   (bs_eff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      free_map_in    = free_map_ff;
      remaining_in   = remaining_ff;
      block_count_in = block_count_ff;
      block_size_in  = block_size_ff;
      name_in        = name_ff;
      need_in        = need_ff;
      idx_in         = idx_ff;
      run_len_in     = run_len_ff;
      run_start_in   = run_start_ff;
      at_in          = at_ff;
      sz_in          = sz_ff;
      ptr_in         = ptr_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_name_in    = rsp_name_ff;
      rsp_start_in   = rsp_start_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_last_in    = rsp_last_ff;
      div_start      = 1'b0;
      dir_raddr      = ptr_ff;
      dir_waddr      = ptr_ff;
      dir_wdata      = dir_rd_ff;
      dir_we         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               name_in      = req_file_name;
               rsp_name_in  = req_file_name;
               rsp_start_in = '0;
               rsp_size_in  = '0;
               rsp_last_in  = 1'b1;
               case (req_kind)
                  cba_pkg::KIND_INSERT: begin
                     if (entry_count_ff >= CNTW'(MAX_FILES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cba_pkg::ST_FULL;
                     end else if (req_file_size > remaining_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cba_pkg::ST_NO_MEM;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  cba_pkg::KIND_DELETE: begin
                     if (entry_count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cba_pkg::ST_ABSENT;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_FIND;
                     end
                  end
                  cba_pkg::KIND_LIST: begin
                     if (entry_count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cba_pkg::ST_EMPTY;
                        rsp_name_in   = '0;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_LST_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               need_in    = div_quo + W'(div_rem != '0);
               idx_in     = '0;
               run_len_in = '0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff >= n_blocks) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cba_pkg::ST_NO_RUN;
               rsp_name_in   = name_ff;
               rsp_start_in  = '0;
               rsp_size_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else if (free_map_ff[idx_ff[BW-1:0]]) begin
               if ((W+1)'(run_inc) >= need_eff) begin
                  at_in    = run_start_cur;
                  sz_in    = need_ff[ZW-1:0];
                  state_in = S_MARK;
               end else begin
                  run_len_in   = run_inc;
                  run_start_in = run_start_cur;
                  idx_in       = idx_ff + ZW'(1);
               end
            end else begin
               run_len_in = '0;
               idx_in     = idx_ff + ZW'(1);
            end
         end
         S_MARK: begin
            free_map_in    = free_map_ff & ~range_mask;
            prod_in        = PW'(sz_ff) * PW'(bs_eff);
            dir_we         = 1'b1;
            dir_waddr      = entry_count_ff[FW-1:0];
            dir_wdata      = '{name: name_ff, first: at_ff, blocks: sz_ff};
            entry_count_in = entry_count_ff + CNTW'(1);
            state_in       = S_INS_DONE;
         end
         S_INS_DONE: begin
            remaining_in  = (prod_ff >= PW'(remaining_ff)) ? '0
                                                          : remaining_ff - prod_ff[W-1:0];
            rsp_valid_in  = 1'b1;
            rsp_status_in = cba_pkg::ST_INSERTED;
            rsp_name_in   = name_ff;
            rsp_start_in  = cba_pkg::START_W'(at_ff);
            rsp_size_in   = cba_pkg::SIZE_W'(sz_ff);
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_FIND: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (dir_rd_ff.name == name_ff) begin
               at_in    = dir_rd_ff.first;
               sz_in    = dir_rd_ff.blocks;
               state_in = S_FREE;
            end else if (ptr_next >= entry_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cba_pkg::ST_ABSENT;
               rsp_name_in   = name_ff;
               rsp_start_in  = '0;
               rsp_size_in   = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end else begin
               ptr_in   = ptr_ff + FW'(1);
               state_in = S_FIND;
            end
         end
         S_FREE: begin
            free_map_in = free_map_ff | range_mask;
            prod_in     = PW'(sz_ff) * PW'(bs_eff);
            state_in    = S_DEL_DONE;
         end
         S_DEL_DONE: begin
            remaining_in  = (give_back > (PW+1)'({W{1'b1}})) ? {W{1'b1}}
                                                             : give_back[W-1:0];
            rsp_valid_in  = 1'b1;
            rsp_status_in = cba_pkg::ST_DELETED;
            rsp_name_in   = name_ff;
            rsp_start_in  = cba_pkg::START_W'(at_ff);
            rsp_size_in   = cba_pkg::SIZE_W'(sz_ff);
            rsp_last_in   = 1'b1;
            if (ptr_next < entry_count_ff) begin
               state_in = S_SH_RD;
            end else begin
               entry_count_in = entry_count_ff - CNTW'(1);
               state_in       = S_IDLE;
            end
         end
         S_SH_RD: begin
            dir_raddr = ptr_ff + FW'(1);
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            dir_we    = 1'b1;
            dir_waddr = ptr_ff;
            dir_wdata = dir_rd_ff;
            ptr_in    = ptr_ff + FW'(1);
            if (ptr_next + CNTW'(1) < entry_count_ff) begin
               state_in = S_SH_RD;
            end else begin
               entry_count_in = entry_count_ff - CNTW'(1);
               state_in       = S_IDLE;
            end
         end
         S_LST_RD: begin
            state_in = S_LST_EM;
         end
         S_LST_EM: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cba_pkg::ST_ENTRY;
            rsp_name_in   = dir_rd_ff.name;
            rsp_start_in  = cba_pkg::START_W'(dir_rd_ff.first);
            rsp_size_in   = cba_pkg::SIZE_W'(dir_rd_ff.blocks);
            rsp_last_in   = (ptr_next == entry_count_ff);
            if (ptr_next == entry_count_ff) begin
               state_in = S_IDLE;
            end else begin
               ptr_in   = ptr_ff + FW'(1);
               state_in = S_LST_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            cba_pkg::REG_TOTAL_MEMORY: remaining_in   = csr_data;
            cba_pkg::REG_BLOCK_COUNT:  block_count_in = csr_data[cba_pkg::BCNT_W-1:0];
            cba_pkg::REG_BLOCK_SIZE:   block_size_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         free_map_ff    <= '1;
         remaining_ff   <= cba_pkg::RST_TOTAL_MEMORY;
         block_count_ff <= cba_pkg::RST_BLOCK_COUNT;
         block_size_ff  <= cba_pkg::RST_BLOCK_SIZE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         free_map_ff    <= free_map_in;
         remaining_ff   <= remaining_in;
         block_count_ff <= block_count_in;
         block_size_ff  <= block_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      name_ff       <= name_in;
      need_ff       <= need_in;
      idx_ff        <= idx_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      at_ff         <= at_in;
      sz_ff         <= sz_in;
      ptr_ff        <= ptr_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_name_ff   <= rsp_name_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_name  = rsp_name_ff;
   assign rsp_start_block = rsp_start_ff;
   assign rsp_size_blocks = rsp_size_ff;
   assign rsp_last        = rsp_last_ff;

   `CBA_ASSERT(a_count_bound, clock, reset,
      entry_count_ff <= CNTW'(MAX_FILES), "entry count over directory depth")
   `CBA_ASSERT(a_div_in_state, clock, reset,
      !div_done || state_ff == S_DIV, "divider done outside divide state")
   `CBA_ASSERT_NEXT(a_full_refuse, clock, reset,
      accept && req_kind == cba_pkg::KIND_INSERT && entry_count_ff == CNTW'(MAX_FILES),
      rsp_valid && rsp_status == cba_pkg::ST_FULL, "full directory not refused")
   `CBA_ASSERT_NEXT(a_ins_result, clock, reset, state_ff == S_INS_DONE,
      rsp_valid && rsp_last && state_ff == S_IDLE, "insert result missing")

endmodule

`default_nettype wire
